// ----- rtl/assert_macros.svh -----
// assertion helpers used by the compressor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PSRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define PSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define PSRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define PSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/psrc_pkg.sv -----
package psrc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACE_CENTER_X  = 4'd0,
        CFG_SPACE_CENTER_Y  = 4'd1,
        CFG_SPACE_CENTER_Z  = 4'd2,
        CFG_SPACE_EXTENT    = 4'd3,
        CFG_TIME_CENTER     = 4'd4,
        CFG_TIME_EXTENT     = 4'd5,
        CFG_WAVELENGTH_LOW  = 4'd6,
        CFG_WAVELENGTH_SPAN = 4'd7
    } t_cfg_reg;

    localparam logic [30:0] RST_SPACE_EXTENT = 31'd1024000;
    localparam logic [30:0] RST_TIME_EXTENT  = 31'd204800;
    localparam logic [21:0] RST_WL_LOW       = 22'd15360;
    localparam logic [21:0] RST_WL_SPAN      = 22'd209920;

    // 1239.842 nm*eV in 1/256 nm times 2^-20 eV
    localparam logic [53:0] WAVE_K = 54'd332817552638;

    localparam logic [15:0] CODE_OVF = 16'h8000;
    localparam logic [7:0]  BYTE_MAX = 8'hff;

    // quotient bits of the two dividers
    localparam int POS_QW     = 17;
    localparam int POS_DW     = 32;
    localparam int WAVE_QW    = 9;
    localparam int WAVE_DW    = 55;
    localparam int DIV_STAGES = POS_QW;

    // stages 1..4 prepare, then the divider, then the output register
    localparam int PRE_ST = 4;
    localparam int NST    = PRE_ST + DIV_STAGES + 1;

    localparam int NCH = 4;

    typedef struct packed {
        logic [31:0] rec;
        logic [7:0]  slot;
        logic [7:0]  pol_x;
        logic [7:0]  pol_y;
        logic [7:0]  pol_z;
        logic [5:0]  flag;
        logic [7:0]  mat;
        logic [NCH-1:0] neg;
        logic        under;
    } t_side;

    // round((p+1)*127) with p in Q1.14, saturated to a byte
    function automatic logic [7:0] pol_byte(input logic signed [15:0] p);
        logic signed [17:0] s;
        logic [22:0] n;
        logic [9:0]  q;
        s = $signed({{2{p[15]}}, p}) + 18'sd16384;
        n = 23'(s[15:0]) * 23'd127;
        q = 10'((n + 23'd8192) >> 14);
        if (s[17] || (s == 18'sd0)) begin
            return 8'd0;
        end else if (q > 10'd255) begin
            return BYTE_MAX;
        end
        return q[7:0];
    endfunction

    // one-based index of the lowest set bit, zero if none
    function automatic logic [5:0] lowest_bit(input logic [31:0] f);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = 31; i >= 0; i--) begin
            if (f[i]) begin
                idx = 6'(i + 1);
            end
        end
        return idx;
    endfunction

    function automatic logic [15:0] fmt_code(input logic ovf, input logic neg,
                                             input logic [POS_QW-1:0] q);
        logic [POS_QW-1:0] nq;
        nq = POS_QW'(~q + 1'b1);
        if (ovf) begin
            return CODE_OVF;
        end else if (neg) begin
            if (q > POS_QW'(32768)) begin
                return CODE_OVF;
            end
            return nq[15:0];
        end else if (q > POS_QW'(32767)) begin
            return CODE_OVF;
        end
        return q[15:0];
    endfunction

    function automatic logic [7:0] fmt_wave(input logic under, input logic ovf,
                                            input logic [WAVE_QW-1:0] q);
        if (under) begin
            return 8'd0;
        end else if (ovf || (q > WAVE_QW'(255))) begin
            return BYTE_MAX;
        end
        return q[7:0];
    endfunction

endpackage

// ----- rtl/psrc_div.sv -----
// restoring divider, one quotient bit per stage; stages past Q_W just hold
module psrc_div
    import psrc_pkg::*;
#(
    parameter int DEN_W  = POS_DW,
    parameter int Q_W    = POS_QW,
    parameter int STAGES = DIV_STAGES
) (
    input  logic              i_clk,
    input  logic [STAGES-1:0] i_load,
    input  logic              i_ovf,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [Q_W-1:0]    i_bits,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_ovf,
    output logic [Q_W-1:0]    o_q
);

    logic [DEN_W-1:0] r_rem  [STAGES];
    logic [DEN_W-1:0] r_den  [STAGES];
    logic [Q_W-1:0]   r_bits [STAGES];
    logic [Q_W-1:0]   r_q    [STAGES];
    logic             r_ovf  [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [DEN_W-1:0] w_rem, w_den, n_rem;
        logic [Q_W-1:0]   w_bits, w_q, n_bits, n_q;
        logic             w_ovf;

        if (g == 0) begin : g_first
            assign w_rem  = i_rem;
            assign w_den  = i_den;
            assign w_bits = i_bits;
            assign w_q    = '0;
            assign w_ovf  = i_ovf;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_bits = r_bits[g-1];
            assign w_q    = r_q[g-1];
            assign w_ovf  = r_ovf[g-1];
        end

        if (g < Q_W) begin : g_step
            logic [DEN_W:0] w_t, w_diff;
            logic           w_ge;
            assign w_t    = {w_rem, w_bits[Q_W-1]};
            assign w_ge   = (w_t >= {1'b0, w_den});
            assign w_diff = w_t - {1'b0, w_den};
            assign n_rem  = w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
            assign n_bits = {w_bits[Q_W-2:0], 1'b0};
            assign n_q    = {w_q[Q_W-2:0], w_ge};
        end else begin : g_hold
            assign n_rem  = w_rem;
            assign n_bits = w_bits;
            assign n_q    = w_q;
        end

        always_ff @(posedge i_clk) begin
            if (i_load[g]) begin
                r_rem[g]  <= n_rem;
                r_den[g]  <= w_den;
                r_bits[g] <= n_bits;
                r_q[g]    <= n_q;
                r_ovf[g]  <= w_ovf;
            end
        end
    end

    assign o_ovf = r_ovf[STAGES-1];
    assign o_q   = r_q[STAGES-1];

endmodule

// ----- rtl/photon_step_record_compressor.sv -----
// photon step record compressor
// input channel: one step point per request (i_in_valid / o_in_ready) with the
// record address, position, time, polarization, energy, flags and material.
// output channel: one packed record per request (o_out_valid / i_out_ready),
// in the same order as the inputs.
// config: i_cfg_we writes i_cfg_data into register i_cfg_idx at the clock edge;
// write only while no request is in flight. unknown indexes are ignored.
// an accepted request goes through the prepare stages, the divider and the output register.
// throughput: one request per cycle while the output is not stalled; the depth is set
// by the 17-stage restoring dividers for position and time (one quotient bit per
// stage); the wavelength divider has the same stages but makes only 9 quotient bits.
// each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and the input keeps being
// accepted while a finished record waits at the output.
// a receiver stall holds the output record; requests pile up in the pipe
// until every stage is full, then o_in_ready drops.
// reset (synchronous, active low) empties the pipe and loads the default
// configuration; there is no other start-up sequence.
`include "assert_macros.svh"

module photon_step_record_compressor
    import psrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_record_index,
    input  logic [7:0]            i_slot_index,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic signed [31:0]    i_global_time,
    input  logic signed [15:0]    i_pol_x,
    input  logic signed [15:0]    i_pol_y,
    input  logic signed [15:0]    i_pol_z,
    input  logic [31:0]           i_kinetic_energy,
    input  logic [31:0]           i_history_flag,
    input  logic [7:0]            i_material_code,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_out_record_index,
    output logic [7:0]            o_out_slot_index,
    output logic signed [15:0]    o_pos_x_code,
    output logic signed [15:0]    o_pos_y_code,
    output logic signed [15:0]    o_pos_z_code,
    output logic signed [15:0]    o_time_code,
    output logic [15:0]           o_pol_xy_word,
    output logic [15:0]           o_pol_z_wave_word,
    output logic [15:0]           o_material_word,
    output logic [15:0]           o_flag_word
);

    // configuration registers
    logic signed [31:0] r_cfg_cx, r_cfg_cy, r_cfg_cz, r_cfg_tc;
    logic [30:0]        r_cfg_sext, r_cfg_text;
    logic [21:0]        r_cfg_wl, r_cfg_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cx   <= '0;
            r_cfg_cy   <= '0;
            r_cfg_cz   <= '0;
            r_cfg_sext <= RST_SPACE_EXTENT;
            r_cfg_tc   <= '0;
            r_cfg_text <= RST_TIME_EXTENT;
            r_cfg_wl   <= RST_WL_LOW;
            r_cfg_span <= RST_WL_SPAN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SPACE_CENTER_X:  r_cfg_cx   <= i_cfg_data;
                CFG_SPACE_CENTER_Y:  r_cfg_cy   <= i_cfg_data;
                CFG_SPACE_CENTER_Z:  r_cfg_cz   <= i_cfg_data;
                CFG_SPACE_EXTENT:    r_cfg_sext <= i_cfg_data[30:0];
                CFG_TIME_CENTER:     r_cfg_tc   <= i_cfg_data;
                CFG_TIME_EXTENT:     r_cfg_text <= i_cfg_data[30:0];
                CFG_WAVELENGTH_LOW:  r_cfg_wl   <= i_cfg_data[21:0];
                CFG_WAVELENGTH_SPAN: r_cfg_span <= i_cfg_data[21:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NST:1]   r_v;
    logic [NST+1:1] adv;
    logic [NST:1]   w_vin;

    always_comb begin
        adv[NST+1] = i_out_ready;
        for (int k = NST; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign w_vin = {r_v[NST-1:1], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign o_in_ready  = adv[1];
    assign o_out_valid = r_v[NST];

    // channel views: x, y, z, time
    logic signed [31:0] w_pos [NCH];
    logic signed [31:0] w_ctr [NCH];
    logic [30:0]        w_ext [NCH];

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign w_pos[3] = i_global_time;
    assign w_ctr[0] = r_cfg_cx;
    assign w_ctr[1] = r_cfg_cy;
    assign w_ctr[2] = r_cfg_cz;
    assign w_ctr[3] = r_cfg_tc;
    assign w_ext[0] = r_cfg_sext;
    assign w_ext[1] = r_cfg_sext;
    assign w_ext[2] = r_cfg_sext;
    assign w_ext[3] = r_cfg_text;

    t_side r_side [1:NST-1];
    t_side n_side1, n_side2;

    logic signed [32:0]  r_p1_d    [NCH];
    logic [32:0]         r_p2_mag  [NCH];
    logic [48:0]         r_p3_num  [NCH];
    logic                r_p4_ovf  [NCH];
    logic [POS_DW-1:0]   r_p4_rem  [NCH];
    logic [POS_QW-1:0]   r_p4_bits [NCH];
    logic [POS_DW-1:0]   w_pden    [NCH];

    logic [53:0]         r_p1_lowe, r_p1_den, r_p2_den, r_p3_den;
    logic [38:0]         r_p2_magw;
    logic [WAVE_DW-1:0]  r_p3_numw;
    logic                r_p4_ovfw;
    logic [WAVE_DW-1:0]  r_p4_remw, r_p4_denw;
    logic [WAVE_QW-1:0]  r_p4_bitsw;

    always_comb begin
        n_side1       = '0;
        n_side1.rec   = i_record_index;
        n_side1.slot  = i_slot_index;
        n_side1.pol_x = pol_byte(i_pol_x);
        n_side1.pol_y = pol_byte(i_pol_y);
        n_side1.pol_z = pol_byte(i_pol_z);
        n_side1.flag  = lowest_bit(i_history_flag);
        n_side1.mat   = i_material_code;
    end

    // stage 1: centre offsets, wavelength products
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            for (int c = 0; c < NCH; c++) begin
                r_p1_d[c] <= $signed({w_pos[c][31], w_pos[c]})
                           - $signed({w_ctr[c][31], w_ctr[c]});
            end
            r_p1_lowe <= 54'(r_cfg_wl * i_kinetic_energy);
            r_p1_den  <= 54'(r_cfg_span * i_kinetic_energy);
        end
    end

    // signs and wavelength below the window join the sideband at stage 2
    always_comb begin
        n_side2 = r_side[1];
        for (int c = 0; c < NCH; c++) begin
            n_side2.neg[c] = r_p1_d[c][32];
        end
        n_side2.under = (r_p1_lowe >= WAVE_K);
    end

    // stage 2: magnitudes and signs, wavelength distance above the window's low end
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            for (int c = 0; c < NCH; c++) begin
                r_p2_mag[c]       <= r_p1_d[c][32] ? 33'(-r_p1_d[c]) : 33'(r_p1_d[c]);
            end
            r_p2_magw       <= WAVE_K[38:0] - r_p1_lowe[38:0];
            r_p2_den        <= r_p1_den;
        end
    end

    // stage 3: rounding numerators, mag*65534 + ext and magw*510 + den
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int c = 0; c < NCH; c++) begin
                r_p3_num[c] <= {r_p2_mag[c], 16'b0} - {15'b0, r_p2_mag[c], 1'b0}
                             + {18'b0, w_ext[c]};
            end
            r_p3_numw <= {7'b0, r_p2_magw, 9'b0} - {15'b0, r_p2_magw, 1'b0}
                       + {1'b0, r_p2_den};
            r_p3_den  <= r_p2_den;
        end
    end

    // stage 4: quotient overflow and first partial remainder
    for (genvar c = 0; c < NCH; c++) begin : g_pden
        assign w_pden[c] = {w_ext[c], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int c = 0; c < NCH; c++) begin
                r_p4_ovf[c]  <= (r_p3_num[c][48:POS_QW] >= w_pden[c]);
                r_p4_rem[c]  <= r_p3_num[c][48:POS_QW];
                r_p4_bits[c] <= r_p3_num[c][POS_QW-1:0];
            end
            r_p4_ovfw  <= ({9'b0, r_p3_numw[WAVE_DW-1:WAVE_QW]} >= {r_p3_den, 1'b0});
            r_p4_remw  <= {9'b0, r_p3_numw[WAVE_DW-1:WAVE_QW]};
            r_p4_bitsw <= r_p3_numw[WAVE_QW-1:0];
            r_p4_denw  <= {r_p3_den, 1'b0};
        end
    end

    // divider stages
    logic                w_div_ovf [NCH];
    logic [POS_QW-1:0]   w_div_q   [NCH];
    logic                w_wdiv_ovf;
    logic [WAVE_QW-1:0]  w_wdiv_q;

    for (genvar c = 0; c < NCH; c++) begin : g_pdiv
        psrc_div #(
            .DEN_W  (POS_DW),
            .Q_W    (POS_QW),
            .STAGES (DIV_STAGES)
        ) u_div (
            .i_clk  (i_clk),
            .i_load (adv[PRE_ST+DIV_STAGES:PRE_ST+1]),
            .i_ovf  (r_p4_ovf[c]),
            .i_rem  (r_p4_rem[c]),
            .i_bits (r_p4_bits[c]),
            .i_den  (w_pden[c]),
            .o_ovf  (w_div_ovf[c]),
            .o_q    (w_div_q[c])
        );
    end

    psrc_div #(
        .DEN_W  (WAVE_DW),
        .Q_W    (WAVE_QW),
        .STAGES (DIV_STAGES)
    ) u_wave_div (
        .i_clk  (i_clk),
        .i_load (adv[PRE_ST+DIV_STAGES:PRE_ST+1]),
        .i_ovf  (r_p4_ovfw),
        .i_rem  (r_p4_remw),
        .i_bits (r_p4_bitsw),
        .i_den  (r_p4_denw),
        .o_ovf  (w_wdiv_ovf),
        .o_q    (w_wdiv_q)
    );

    // sideband travels with the valid bits
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_side[1] <= n_side1;
        end
        if (adv[2]) begin
            r_side[2] <= n_side2;
        end
        for (int k = 3; k <= NST - 1; k++) begin
            if (adv[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // output register
    logic [31:0] r_out_rec;
    logic [7:0]  r_out_slot;
    logic [15:0] r_out_code [NCH];
    logic [15:0] r_out_pol_xy, r_out_pz_wave, r_out_mat, r_out_flag;
    t_side       w_last;

    assign w_last = r_side[NST-1];

    always_ff @(posedge i_clk) begin
        if (adv[NST]) begin
            r_out_rec  <= w_last.rec;
            r_out_slot <= w_last.slot;
            for (int c = 0; c < NCH; c++) begin
                r_out_code[c] <= fmt_code(w_div_ovf[c], w_last.neg[c], w_div_q[c]);
            end
            r_out_pol_xy  <= {w_last.pol_y, w_last.pol_x};
            r_out_pz_wave <= {fmt_wave(w_last.under, w_wdiv_ovf, w_wdiv_q), w_last.pol_z};
            r_out_mat     <= {8'd0, w_last.mat};
            r_out_flag    <= {2'b0, w_last.flag, 8'd0};
        end
    end

    assign o_out_record_index = r_out_rec;
    assign o_out_slot_index   = r_out_slot;
    assign o_pos_x_code       = r_out_code[0];
    assign o_pos_y_code       = r_out_code[1];
    assign o_pos_z_code       = r_out_code[2];
    assign o_time_code        = r_out_code[3];
    assign o_pol_xy_word      = r_out_pol_xy;
    assign o_pol_z_wave_word  = r_out_pz_wave;
    assign o_material_word    = r_out_mat;
    assign o_flag_word        = r_out_flag;

    // checks
    logic w_in_acc, w_out_acc;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // requests in flight change only by accepts and deliveries
    `PSRC_ASSERT_IMPLY(a_count_kept, i_clk, i_rst_n, $past(i_rst_n),
        $countones(r_v) == $past($countones(r_v)) + $past(32'(w_in_acc))
                           - $past(32'(w_out_acc)))
    `PSRC_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, w_in_acc, r_v[1])
    `PSRC_ASSERT_IMPLY(a_flag_byte, i_clk, i_rst_n, o_out_valid,
        (o_flag_word[15:8] <= 8'd32) && (o_flag_word[7:0] == 8'd0))

endmodule

// ----- verif/photon_step_record_compressor_tb.sv -----
`timescale 1ns / 100ps

module photon_step_record_compressor_tb;
    import psrc_pkg::*;

    localparam int PIPE_LATENCY   = 22;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam int FLOW_STEADY = 0;
    localparam int FLOW_MIXED  = 1;
    localparam int FLOW_CHOKED = 2;

    // indexes past the register list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

    localparam longint unsigned LAMBDA_K  = 64'd332817552638;
    localparam longint unsigned POS_SCALE = 64'd32767;
    localparam logic [15:0]     OUT_OF_RANGE = 16'h8000;

    typedef struct packed {
        logic [31:0]        rec;
        logic [7:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] gtime;
        logic signed [15:0] pol_x;
        logic signed [15:0] pol_y;
        logic signed [15:0] pol_z;
        logic [31:0]        energy;
        logic [31:0]        flags;
        logic [7:0]         mat;
    } step_point_t;

    typedef struct packed {
        logic [31:0] rec;
        logic [7:0]  slot;
        logic [15:0] x_code;
        logic [15:0] y_code;
        logic [15:0] z_code;
        logic [15:0] t_code;
        logic [15:0] pol_xy;
        logic [15:0] pol_z_wave;
        logic [15:0] mat_word;
        logic [15:0] flag_word;
    } step_record_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [31:0]           i_record_index = '0;
    logic [7:0]            i_slot_index = '0;
    logic signed [31:0]    i_pos_x = '0;
    logic signed [31:0]    i_pos_y = '0;
    logic signed [31:0]    i_pos_z = '0;
    logic signed [31:0]    i_global_time = '0;
    logic signed [15:0]    i_pol_x = '0;
    logic signed [15:0]    i_pol_y = '0;
    logic signed [15:0]    i_pol_z = '0;
    logic [31:0]           i_kinetic_energy = '0;
    logic [31:0]           i_history_flag = '0;
    logic [7:0]            i_material_code = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [31:0]           o_out_record_index;
    logic [7:0]            o_out_slot_index;
    logic signed [15:0]    o_pos_x_code;
    logic signed [15:0]    o_pos_y_code;
    logic signed [15:0]    o_pos_z_code;
    logic signed [15:0]    o_time_code;
    logic [15:0]           o_pol_xy_word;
    logic [15:0]           o_pol_z_wave_word;
    logic [15:0]           o_material_word;
    logic [15:0]           o_flag_word;

    // register shadow, follows every write
    logic signed [31:0] ctr_x    = '0;
    logic signed [31:0] ctr_y    = '0;
    logic signed [31:0] ctr_z    = '0;
    logic [30:0]        space_ext = 31'd1024000;
    logic signed [31:0] time_ctr = '0;
    logic [30:0]        time_ext = 31'd204800;
    logic [21:0]        wl_low   = 22'd15360;
    logic [21:0]        wl_span  = 22'd209920;

    step_point_t  pending_points[$];
    step_record_t expected_records[$];
    step_point_t  next_point;
    step_point_t  seen_point;
    step_record_t want;

    logic in_taken = 1'b0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   send_mode = FLOW_MIXED;
    int   recv_mode = FLOW_MIXED;
    int   points_queued = 0;
    int   points_accepted = 0;
    int   records_checked = 0;
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   settings_used = 1;

    photon_step_record_compressor uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_record_index     (i_record_index),
        .i_slot_index       (i_slot_index),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_global_time      (i_global_time),
        .i_pol_x            (i_pol_x),
        .i_pol_y            (i_pol_y),
        .i_pol_z            (i_pol_z),
        .i_kinetic_energy   (i_kinetic_energy),
        .i_history_flag     (i_history_flag),
        .i_material_code    (i_material_code),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_record_index (o_out_record_index),
        .o_out_slot_index   (o_out_slot_index),
        .o_pos_x_code       (o_pos_x_code),
        .o_pos_y_code       (o_pos_y_code),
        .o_pos_z_code       (o_pos_z_code),
        .o_time_code        (o_time_code),
        .o_pol_xy_word      (o_pol_xy_word),
        .o_pol_z_wave_word  (o_pol_z_wave_word),
        .o_material_word    (o_material_word),
        .o_flag_word        (o_flag_word)
    );

    always #4 i_clk = ~i_clk;

    // 32767 * (v - c) / ext, rounded half away from zero, 16 bit or overflow code
    function automatic logic [15:0] scale_code(input logic signed [31:0] v,
                                               input logic signed [31:0] c,
                                               input logic [30:0] ext);
        longint            d;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   q;
        longint unsigned   neg_q;
        d = longint'(v) - longint'(c);
        mag = (d < 0) ? -d : d;
        den = ext;
        if (den == 0) begin
            return OUT_OF_RANGE;
        end
        q = (2 * mag * POS_SCALE + den) / (2 * den);
        if (d < 0) begin
            if (q > 32768) begin
                return OUT_OF_RANGE;
            end
            neg_q = 0 - q;
            return neg_q[15:0];
        end
        if (q > 32767) begin
            return OUT_OF_RANGE;
        end
        return q[15:0];
    endfunction

    function automatic logic [7:0] pol_code(input logic signed [15:0] p);
        longint          n;
        longint unsigned un;
        longint unsigned q;
        n = (longint'(p) + 16384) * 127;
        if (n <= 0) begin
            return 8'd0;
        end
        un = n;
        q = (2 * un + 16384) / 32768;
        return (q > 255) ? 8'hff : q[7:0];
    endfunction

    // wavelength placed in the window, exact rational with half-away rounding
    function automatic logic [7:0] wave_code(input logic [31:0] energy);
        longint unsigned e64;
        longint unsigned lowe;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        e64 = energy;
        if (e64 == 0) begin
            return 8'hff;
        end
        lowe = longint'(wl_low) * e64;
        if (LAMBDA_K <= lowe) begin
            return 8'd0;
        end
        mag = LAMBDA_K - lowe;
        if (wl_span == 0) begin
            return 8'hff;
        end
        den = e64 * longint'(wl_span);
        q = (2 * mag * 255 + den) / (2 * den);
        return (q > 255) ? 8'hff : q[7:0];
    endfunction

    function automatic logic [7:0] lowest_flag(input logic [31:0] f);
        for (int i = 0; i < 32; i++) begin
            if (f[i]) begin
                return 8'(i + 1);
            end
        end
        return 8'd0;
    endfunction

    function automatic step_record_t compress_point(input step_point_t p);
        step_record_t r;
        r.rec        = p.rec;
        r.slot       = p.slot;
        r.x_code     = scale_code(p.pos_x, ctr_x, space_ext);
        r.y_code     = scale_code(p.pos_y, ctr_y, space_ext);
        r.z_code     = scale_code(p.pos_z, ctr_z, space_ext);
        r.t_code     = scale_code(p.gtime, time_ctr, time_ext);
        r.pol_xy     = {pol_code(p.pol_y), pol_code(p.pol_x)};
        r.pol_z_wave = {wave_code(p.energy), pol_code(p.pol_z)};
        r.mat_word   = {8'h00, p.mat};
        r.flag_word  = {lowest_flag(p.flags), 8'h00};
        return r;
    endfunction

    function automatic int pick_send_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == FLOW_STEADY || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_recv_stall(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == FLOW_STEADY) begin
            return 0;
        end else if (mode == FLOW_CHOKED) begin
            return (r < 35) ? $urandom_range(5, 40) : 0;
        end else if (r < 80) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    // mostly within the domain and a little past its edges, some anywhere in 32 bits
    function automatic logic [31:0] pick_coord(input logic signed [31:0] c,
                                               input logic [30:0] ext);
        longint unsigned r64;
        longint unsigned reach;
        longint unsigned off;
        longint          v;
        if ($urandom_range(0, 9) < 3) begin
            return $urandom;
        end
        r64 = $urandom;
        reach = ext;
        reach = reach + reach / 8 + 2;
        off = (r64 * reach) >> 32;
        if ($urandom_range(0, 1) == 1) begin
            v = longint'(c) + longint'(off);
        end else begin
            v = longint'(c) - longint'(off);
        end
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic logic [15:0] pick_pol();
        int v;
        if ($urandom_range(0, 19) == 0) begin
            return 16'($urandom);
        end
        v = int'($urandom_range(0, 32768)) - 16384;
        return 16'(v);
    endfunction

    // mostly energies that land around the current wavelength window
    function automatic logic [31:0] pick_energy();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned w;
        longint unsigned e;
        longint unsigned r64;
        longint unsigned wl64;
        longint unsigned sp64;
        if ($urandom_range(0, 4) == 0) begin
            e = $urandom;
            return (e == 0) ? 32'd1 : e[31:0];
        end
        wl64 = wl_low;
        sp64 = wl_span;
        lo = (wl64 > sp64 / 8) ? wl64 - sp64 / 8 : 1;
        hi = wl64 + sp64 + sp64 / 8 + 1;
        r64 = $urandom;
        w = lo + ((r64 * (hi - lo + 1)) >> 32);
        e = LAMBDA_K / w;
        if (e == 0 || e > 64'h0000_0000_ffff_ffff) begin
            e = $urandom | 1;
        end
        return e[31:0];
    endfunction

    function automatic logic [31:0] pick_flags();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 32'd0;
        end else if (r < 6) begin
            return $urandom << $urandom_range(0, 31);
        end
        return $urandom;
    endfunction

    function automatic step_point_t random_point();
        step_point_t p;
        p.rec    = $urandom;
        p.slot   = 8'($urandom_range(0, 255));
        p.pos_x  = pick_coord(ctr_x, space_ext);
        p.pos_y  = pick_coord(ctr_y, space_ext);
        p.pos_z  = pick_coord(ctr_z, space_ext);
        p.gtime  = pick_coord(time_ctr, time_ext);
        p.pol_x  = pick_pol();
        p.pol_y  = pick_pol();
        p.pol_z  = pick_pol();
        p.energy = pick_energy();
        p.flags  = pick_flags();
        p.mat    = 8'($urandom_range(0, 255));
        return p;
    endfunction

    function automatic step_point_t base_point();
        step_point_t p;
        p = '0;
        p.energy = 32'(LAMBDA_K / 102400);
        p.flags  = 32'd1;
        return p;
    endfunction

    task automatic queue_point(input step_point_t p);
        pending_points.push_back(p);
        points_queued++;
    endtask

    task automatic queue_random(input int n);
        repeat (n) queue_point(random_point());
    endtask

    // wait until every request is through, then let the pipe empty
    task automatic settle();
        while (points_accepted != points_queued || expected_records.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SPACE_CENTER_X:  ctr_x     = data;
            CFG_SPACE_CENTER_Y:  ctr_y     = data;
            CFG_SPACE_CENTER_Z:  ctr_z     = data;
            CFG_SPACE_EXTENT:    space_ext = data[30:0];
            CFG_TIME_CENTER:     time_ctr  = data;
            CFG_TIME_EXTENT:     time_ext  = data[30:0];
            CFG_WAVELENGTH_LOW:  wl_low    = data[21:0];
            CFG_WAVELENGTH_SPAN: wl_span   = data[21:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] cz, input logic [31:0] sx,
                                  input logic [31:0] tc, input logic [31:0] tx,
                                  input logic [31:0] wl, input logic [31:0] ws);
        write_reg(CFG_SPACE_CENTER_X, cx);
        write_reg(CFG_SPACE_CENTER_Y, cy);
        write_reg(CFG_SPACE_CENTER_Z, cz);
        write_reg(CFG_SPACE_EXTENT, sx);
        write_reg(CFG_TIME_CENTER, tc);
        write_reg(CFG_TIME_EXTENT, tx);
        write_reg(CFG_WAVELENGTH_LOW, wl);
        write_reg(CFG_WAVELENGTH_SPAN, ws);
        settings_used++;
    endtask

    task automatic write_random_regs();
        write_all_regs($urandom, $urandom, $urandom,
                       $urandom_range(1, 32'h7fffffff), $urandom,
                       $urandom_range(1, 32'h7fffffff),
                       $urandom_range(0, 1000 * 256), $urandom_range(1, 1500 * 256));
    endtask

    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("record %0d %s: expected %h, got %h",
                         records_checked, field, exp_v, act_v);
            end
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
                next_point = pending_points.pop_front();
                i_record_index   <= next_point.rec;
                i_slot_index     <= next_point.slot;
                i_pos_x          <= next_point.pos_x;
                i_pos_y          <= next_point.pos_y;
                i_pos_z          <= next_point.pos_z;
                i_global_time    <= next_point.gtime;
                i_pol_x          <= next_point.pol_x;
                i_pol_y          <= next_point.pol_y;
                i_pol_z          <= next_point.pol_z;
                i_kinetic_energy <= next_point.energy;
                i_history_flag   <= next_point.flags;
                i_material_code  <= next_point.mat;
                i_in_valid       <= 1'b1;
                send_gap = pick_send_gap(send_mode);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_stall != 0) begin
            recv_stall = recv_stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            recv_stall = pick_recv_stall(recv_mode);
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                seen_point.rec    = i_record_index;
                seen_point.slot   = i_slot_index;
                seen_point.pos_x  = i_pos_x;
                seen_point.pos_y  = i_pos_y;
                seen_point.pos_z  = i_pos_z;
                seen_point.gtime  = i_global_time;
                seen_point.pol_x  = i_pol_x;
                seen_point.pol_y  = i_pol_y;
                seen_point.pol_z  = i_pol_z;
                seen_point.energy = i_kinetic_energy;
                seen_point.flags  = i_history_flag;
                seen_point.mat    = i_material_code;
                expected_records.push_back(compress_point(seen_point));
                points_accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_records.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("record %0d arrived with nothing outstanding",
                                 records_checked);
                    end
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_index", want.rec, o_out_record_index);
                    check_field("slot_index", want.slot, o_out_slot_index);
                    check_field("pos_x_code", want.x_code, $unsigned(o_pos_x_code));
                    check_field("pos_y_code", want.y_code, $unsigned(o_pos_y_code));
                    check_field("pos_z_code", want.z_code, $unsigned(o_pos_z_code));
                    check_field("time_code", want.t_code, $unsigned(o_time_code));
                    check_field("pol_xy_word", want.pol_xy, o_pol_xy_word);
                    check_field("pol_z_wave_word", want.pol_z_wave, o_pol_z_wave_word);
                    check_field("material_word", want.mat_word, o_material_word);
                    check_field("flag_word", want.flag_word, o_flag_word);
                end
                records_checked++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("photon_step_record_compressor: mismatch");
                $finish;
            end
        end
    end

    initial begin
        step_point_t p;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default window: 60 nm .. 880 nm, extents 1000 mm and 200 ns
        p = base_point();
        queue_point(p);
        p = base_point();
        p.rec    = '1;
        p.slot   = '1;
        p.pos_x  = 32'sh7fffffff;
        p.pos_y  = 32'sh80000000;
        p.pos_z  = 32'sd1024000;
        p.gtime  = -32'sd204800;
        p.pol_x  = 16'sd16384;
        p.pol_y  = -16'sd16384;
        p.energy = '1;
        p.flags  = 32'h8000_0000;
        p.mat    = '1;
        queue_point(p);
        // just past full scale: -32768 is still valid, +32768 is not
        p = base_point();
        p.pos_x  = 32'sd1024031;
        p.pos_y  = -32'sd1024031;
        p.pos_z  = -32'sd1024047;
        p.gtime  = 32'sd204806;
        p.pol_x  = -16'sd8192;
        p.pol_y  = 16'sh7fff;
        p.pol_z  = 16'sh8000;
        p.flags  = 32'h0001_0000;
        queue_point(p);
        p = base_point();
        p.pos_x  = -32'sd1024047;
        p.gtime  = -32'sd204806;
        p.energy = 32'd1;
        p.flags  = 32'd0;
        queue_point(p);
        // energy zero, then both window edges
        p = base_point();
        p.energy = 32'd0;
        queue_point(p);
        p = base_point();
        p.energy = 32'd21667810;
        queue_point(p);
        p = base_point();
        p.energy = 32'd21667809;
        queue_point(p);
        p = base_point();
        p.energy = 32'd1477351;
        p.flags  = 32'h0000_0006;
        queue_point(p);
        p = base_point();
        p.energy = 32'd1477352;
        p.flags  = 32'hffff_fff8;
        queue_point(p);
        queue_random(300);
        settle();

        // no idling at all
        send_mode = FLOW_STEADY;
        recv_mode = FLOW_STEADY;
        write_random_regs();
        queue_random(400);
        settle();

        // smallest space extent, widest window; pipe fills up behind stalls
        recv_mode = FLOW_CHOKED;
        write_all_regs(32'h7fffffff, 32'h80000000, 32'h0, 32'd1, 32'h80000000,
                       32'h7fffffff, 32'd0, 32'h3fffff);
        queue_random(250);
        settle();

        send_mode = FLOW_MIXED;
        recv_mode = FLOW_MIXED;
        write_all_regs(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff,
                       32'h7fffffff, 32'd1, 32'h3fffff, 32'd1);
        queue_random(250);
        settle();

        // extents that give exact halves
        write_all_regs(32'h0, 32'h0, 32'h0, 32'd2, 32'h0, 32'd65534,
                       32'd15360, 32'd209920);
        p = base_point();
        p.pos_x = 32'sd1;
        p.pos_y = -32'sd1;
        p.pos_z = 32'sd3;
        p.gtime = 32'sd1;
        queue_point(p);
        p = base_point();
        p.pos_x = -32'sd2;
        p.pos_y = 32'sd2;
        p.pos_z = -32'sd3;
        p.gtime = -32'sd1;
        queue_point(p);
        settle();

        // zero extents and zero span
        write_reg(CFG_SPACE_EXTENT, 32'd0);
        write_reg(CFG_TIME_EXTENT, 32'd0);
        write_reg(CFG_WAVELENGTH_SPAN, 32'd0);
        settings_used++;
        p = base_point();
        p.energy = 32'd1000;
        queue_point(p);
        p = base_point();
        p.energy = 32'hffff_ffff;
        queue_point(p);
        p = base_point();
        p.energy = 32'd0;
        queue_point(p);
        queue_random(50);
        settle();

        // writes to unknown indexes must leave the registers alone
        write_reg(CFG_IDX_SPARE_LO, 32'hffffffff);
        write_reg(CFG_IDX_SPARE_HI, 32'h12345678);
        p = base_point();
        p.pos_x  = 32'sd5;
        p.energy = 32'd1000;
        queue_point(p);
        settle();

        for (int k = 0; k < 3; k++) begin
            write_random_regs();
            queue_random(250);
            settle();
        end

        $display("covered %0d step points under %0d register settings, with zero",
                 points_accepted, settings_used);
        $display("extents, zero span, overflowing codes and saturating bytes; %0d records, %0d bad fields",
                 records_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("photon_step_record_compressor: match");
        end else begin
            $display("photon_step_record_compressor: mismatch");
        end
        $finish;
    end

endmodule
